/* hdl/pnf_pkg.sv */
// Package for the printf number formatter: sequencer states, ASCII codes,
// digit-unit handshake structs and the digit-to-character function.
// No dependencies.
`default_nettype none

package pnf_pkg;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_WAIT,
        S_PRE,
        S_DIG
    } t_state;

    localparam t_byte CH_PERCENT = 8'h25;
    localparam t_byte CH_C       = 8'h63;
    localparam t_byte CH_D       = 8'h64;
    localparam t_byte CH_I       = 8'h69;
    localparam t_byte CH_U       = 8'h75;
    localparam t_byte CH_X_LO    = 8'h78;
    localparam t_byte CH_X_UP    = 8'h58;
    localparam t_byte CH_P       = 8'h70;
    localparam t_byte CH_ZERO    = 8'h30;
    localparam t_byte CH_MINUS   = 8'h2d;
    localparam t_byte CH_A_LO    = 8'h61;
    localparam t_byte CH_A_UP    = 8'h41;
    localparam t_byte ERR_BYTE   = 8'h00;

    // ceil(2^35 / 10): floor(n * RECIP10 / 2^35) == n / 10 for any 32-bit n
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [3:0]  HEX_SHIFT   = 4'd4;

    typedef struct packed {
        logic start;
        logic hex;
    } t_du_req;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } t_du_rsp;

    function automatic t_byte digit_char(input logic [3:0] d, input logic upper);
        t_byte base;
        if (d < 4'd10) begin
            base = CH_ZERO;
            return base + {4'b0, d};
        end
        base = upper ? CH_A_UP : CH_A_LO;
        return base + {4'b0, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

/* hdl/pnf_if.sv */
// Valid/ready channel interfaces for the format input and the result output.
// Depends on pnf_pkg.
`default_nettype none

interface pnf_in_if;
    import pnf_pkg::*;
    logic        valid;
    logic        ready;
    t_byte       fmt_byte;
    logic [63:0] arg_value;

    modport source (output valid, output fmt_byte, output arg_value, input ready);
    modport sink   (input valid, input fmt_byte, input arg_value, output ready);
endinterface

interface pnf_out_if;
    import pnf_pkg::*;
    logic        valid;
    logic        ready;
    t_byte       out_byte;
    logic        last;
    logic        error;
    logic [31:0] byte_total;

    modport source (output valid, output out_byte, output last, output error,
                    output byte_total, input ready);
    modport sink   (input valid, input out_byte, input last, input error,
                    input byte_total, output ready);
endinterface

`default_nettype wire

/* hdl/printf_number_formatter.sv */
// printf number formatter: format bytes in, ASCII result words out.
//
// Input channel i_fmt carries a format byte and a 64-bit argument; output
// channel o_res carries out_byte, last, error and the running byte_total.
// A plain byte is echoed as one word; '%' is swallowed and arms the next
// byte as a conversion (c d i u x X p %); any other specifier gives one
// word with error set and out_byte zero. The final word of an input has
// last set; a lone '%' produces no word.
// Timing: i_fmt.ready is high only while the sequencer is idle. Numeric
// conversions run the shared digit unit through S_CONV and S_WAIT once
// per digit (multiply by the reciprocal of ten, then back-multiply and
// subtract; hex shifts). Each output word then takes one cycle when
// o_res.ready is high. An echo passes through S_PRE and the output
// register; a number first runs the digit loop.
// The output register holds one word and loads the next only when it is
// empty or o_res.ready is high. A stalled receiver holds the word and the
// sequencer waits. Synchronous active-low reset clears the pending '%', the
// byte count, the output valid and the sequencer; no clearing pass is needed.
`default_nettype none

module printf_number_formatter
    import pnf_pkg::*;
#(
    parameter int MAX_DIGITS = 20
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pnf_in_if.sink    i_fmt,
    pnf_out_if.source o_res
);

    localparam int IW = $clog2(MAX_DIGITS);

    t_state         r_state, n_state;
    logic           r_pending, n_pending;
    logic [31:0]    r_count, n_count;
    t_byte          r_pre0, n_pre0;
    t_byte          r_pre1, n_pre1;
    logic [1:0]     r_pre_cnt, n_pre_cnt;
    logic           r_pre_idx, n_pre_idx;
    logic           r_num_en, n_num_en;
    logic           r_hex, n_hex;
    logic           r_upper, n_upper;
    logic           r_err, n_err;
    logic [63:0]    r_n, n_n;
    logic [IW-1:0]  r_wr_idx, n_wr_idx;
    logic [IW-1:0]  r_rd_idx, n_rd_idx;
    logic           r_out_valid, n_out_valid;
    t_byte          r_out_byte, n_out_byte;
    logic           r_out_last, n_out_last;
    logic           r_out_err, n_out_err;
    logic [31:0]    r_out_total, n_out_total;

    logic [3:0]     r_digits [MAX_DIGITS];
    logic [3:0]     r_dig;
    logic           dig_we;

    t_du_req        du_req;
    t_du_rsp        du_rsp;
    logic [63:0]    du_quot;

    logic           load;
    logic           pre_last;
    logic [31:0]    low;
    t_byte          b;

    pnf_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .i_value (r_n),
        .o_rsp   (du_rsp),
        .o_quot  (du_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_count     = r_count;
        n_pre0      = r_pre0;
        n_pre1      = r_pre1;
        n_pre_cnt   = r_pre_cnt;
        n_pre_idx   = r_pre_idx;
        n_num_en    = r_num_en;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_err       = r_err;
        n_n         = r_n;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        n_out_total = r_out_total;
        load        = !r_out_valid || o_res.ready;
        n_out_valid = r_out_valid && !o_res.ready;
        du_req.start = 1'b0;
        du_req.hex   = r_hex;
        dig_we      = 1'b0;
        i_fmt.ready = (r_state == S_IDLE);
        pre_last    = (r_pre_idx == (r_pre_cnt == 2'd2));
        b           = i_fmt.fmt_byte;
        low         = i_fmt.arg_value[31:0];

        case (r_state)
            S_IDLE: begin
                if (i_fmt.valid) begin
                    n_pre_idx = 1'b0;
                    n_wr_idx  = '0;
                    n_num_en  = 1'b0;
                    n_hex     = 1'b0;
                    n_upper   = 1'b0;
                    n_err     = 1'b0;
                    n_pre_cnt = 2'd1;
                    n_pre0    = b;
                    n_n       = {32'b0, low};
                    n_state   = S_PRE;
                    if (!r_pending) begin
                        if (b == CH_PERCENT) begin
                            n_pending = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end else begin
                        n_pending = 1'b0;
                        case (b)
                            CH_C: n_pre0 = i_fmt.arg_value[7:0];
                            CH_D, CH_I: begin
                                n_num_en = 1'b1;
                                if (low[31]) begin
                                    n_pre0 = CH_MINUS;
                                    n_n    = {32'b0, 32'd0 - low};
                                end else begin
                                    n_pre_cnt = 2'd0;
                                end
                            end
                            CH_U: begin
                                n_num_en  = 1'b1;
                                n_pre_cnt = 2'd0;
                            end
                            CH_X_LO, CH_X_UP: begin
                                n_num_en  = 1'b1;
                                n_hex     = 1'b1;
                                n_upper   = (b == CH_X_UP);
                                n_pre_cnt = 2'd0;
                            end
                            CH_P: begin
                                n_num_en  = 1'b1;
                                n_hex     = 1'b1;
                                n_pre_cnt = 2'd2;
                                n_pre0    = CH_ZERO;
                                n_pre1    = CH_X_LO;
                                n_n       = i_fmt.arg_value;
                            end
                            CH_PERCENT: n_pre0 = CH_PERCENT;
                            default: n_err = 1'b1;
                        endcase
                        if (n_num_en) begin
                            n_state = S_CONV;
                        end
                    end
                end
            end
            S_CONV: begin
                du_req.start = 1'b1;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (du_rsp.done) begin
                    dig_we   = 1'b1;
                    n_n      = du_quot;
                    n_rd_idx = r_wr_idx;
                    n_wr_idx = r_wr_idx + 1'b1;
                    if (du_quot == 64'd0 || r_wr_idx == IW'(MAX_DIGITS - 1)) begin
                        n_state = (r_pre_cnt != 2'd0) ? S_PRE : S_DIG;
                    end else begin
                        n_state = S_CONV;
                    end
                end
            end
            S_PRE: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_err   = r_err;
                    n_out_last  = pre_last && !r_num_en;
                    if (r_err) begin
                        n_out_byte  = ERR_BYTE;
                        n_out_total = r_count;
                    end else begin
                        n_out_byte  = r_pre_idx ? r_pre1 : r_pre0;
                        n_count     = r_count + 32'd1;
                        n_out_total = n_count;
                    end
                    if (pre_last) begin
                        n_state = r_num_en ? S_DIG : S_IDLE;
                    end else begin
                        n_pre_idx = 1'b1;
                    end
                end
            end
            S_DIG: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_err   = 1'b0;
                    n_out_byte  = digit_char(r_dig, r_upper);
                    n_out_last  = (r_rd_idx == '0);
                    n_count     = r_count + 32'd1;
                    n_out_total = n_count;
                    if (r_rd_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx - 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_count     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre0      <= n_pre0;
        r_pre1      <= n_pre1;
        r_pre_cnt   <= n_pre_cnt;
        r_pre_idx   <= n_pre_idx;
        r_num_en    <= n_num_en;
        r_hex       <= n_hex;
        r_upper     <= n_upper;
        r_err       <= n_err;
        r_n         <= n_n;
        r_wr_idx    <= n_wr_idx;
        r_rd_idx    <= n_rd_idx;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
        r_out_total <= n_out_total;
    end

    // digit scratch, least significant digit first; r_dig tracks the entry
    // at r_rd_idx, a digit written this cycle goes straight through
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_digits[r_wr_idx] <= du_rsp.digit;
            r_dig              <= du_rsp.digit;
        end else begin
            r_dig              <= r_digits[n_rd_idx];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_byte   = r_out_byte;
    assign o_res.last       = r_out_last;
    assign o_res.error      = r_out_err;
    assign o_res.byte_total = r_out_total;

endmodule

`default_nettype wire

/* hdl/pnf_digit_unit.sv */
// Shared digit extraction unit: one base-10 or base-16 step per request.
// Depends on pnf_pkg.
`default_nettype none

module pnf_digit_unit
    import pnf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_du_req     i_req,
    input  wire logic [63:0] i_value,
    output t_du_rsp          o_rsp,
    output logic [63:0]      o_quot
);

    logic        r_busy;
    logic        r_hex;
    logic [63:0] r_val;
    logic [63:0] r_prod;
    logic [28:0] dec_q;
    logic [31:0] dec_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_req.start;
        end
    end

    // product registered before the back-multiply and subtract
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_hex  <= i_req.hex;
            r_val  <= i_value;
            r_prod <= i_value[31:0] * RECIP10;
        end
    end

    always_comb begin
        dec_q    = r_prod[63:RECIP_SHIFT];
        dec_back = {dec_q, 3'b000} + {2'b00, dec_q, 1'b0};
        o_rsp.done = r_busy;
        if (r_hex) begin
            o_rsp.digit = r_val[3:0];
            o_quot      = r_val >> HEX_SHIFT;
        end else begin
            o_rsp.digit = r_val[3:0] - dec_back[3:0];
            o_quot      = {35'b0, dec_q};
        end
    end

endmodule

`default_nettype wire
